@@ rtl/hgta_pkg.sv @@
// Shared types and constants for the hand-gated temperature averager.
// Used by every module under rtl/; no dependencies of its own.
`default_nettype none
package hgta_pkg;

    localparam int MAX_SAMPLES = 4095;
    localparam int CNT_W       = 12;
    localparam int SUM_W       = 32;
    localparam int TEMP_W      = 17;
    localparam int AMB_W       = 15;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 14;
    localparam int MS_W        = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_SAMPLES > 4095) ? 4095 : ((MAX_SAMPLES < 1) ? 1 : MAX_SAMPLES));

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_HAND_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS     = 3'd4;

    localparam logic [THR_W-1:0]         RST_HAND_THRESHOLD = 14'd300;
    localparam logic [MS_W-1:0]          RST_WINDOW_MS      = 16'd3000;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_MIN       = 17'sd3200;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_MAX       = 17'sd4000;
    localparam logic [MS_W-1:0]          RST_HOLDOFF_MS     = 16'd500;

    // event kinds on m_tuser
    localparam logic EV_FINISHED = 1'b0;
    localparam logic EV_REMOVED  = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0]         hand_threshold;
        logic [MS_W-1:0]          window_ms;
        logic signed [TEMP_W-1:0] temp_min;
        logic signed [TEMP_W-1:0] temp_max;
        logic [MS_W-1:0]          holdoff_ms;
    } cfg_t;

    // one queued job for the back end
    typedef struct packed {
        logic                    kind;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } job_t;

endpackage
`default_nettype wire

@@ rtl/hgta_front.sv @@
// Front end: takes input transactions, tracks hand/session state, sums samples
// and queues finish/removal jobs. Depends on hgta_pkg.
`default_nettype none
module hgta_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire hgta_pkg::cfg_t          cfg,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [63:0]             s_tdata,
    input  wire logic                    q_full,
    output logic                         q_push,
    output hgta_pkg::job_t               q_job
);

    logic                                    hand_reg, hand_next;
    logic                                    meas_reg, meas_next;
    logic [hgta_pkg::TIME_W-1:0]             sess_start_reg, sess_start_next;
    logic [hgta_pkg::TIME_W-1:0]             last_start_reg, last_start_next;
    logic signed [hgta_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [hgta_pkg::CNT_W-1:0]              count_reg, count_next;

    logic signed [hgta_pkg::AMB_W-1:0]       amb;
    logic signed [hgta_pkg::TEMP_W-1:0]      obj;
    logic [hgta_pkg::TIME_W-1:0]             now;
    logic signed [18:0]                      diff;
    logic                                    seen, start, remove, meas_eff, add, done;
    logic [hgta_pkg::TIME_W-1:0]             gap, elapsed, start_eff;
    logic signed [hgta_pkg::SUM_W-1:0]       sum_eff, sum_new;
    logic [hgta_pkg::CNT_W-1:0]              count_eff, count_new;
    logic                                    accept;

    assign amb = s_tdata[14:0];
    assign obj = s_tdata[31:15];
    assign now = s_tdata[63:32];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        diff   = $signed({{2{obj[16]}}, obj}) - $signed({{4{amb[14]}}, amb});
        seen   = diff >= $signed({5'd0, cfg.hand_threshold});
        gap    = now - last_start_reg;
        start  = seen && !hand_reg && (gap > {16'd0, cfg.holdoff_ms});
        remove = !seen && hand_reg;

        meas_eff  = start || meas_reg;
        count_eff = start ? '0 : count_reg;
        sum_eff   = start ? '0 : sum_reg;
        add       = count_eff < hgta_pkg::COUNT_CAP;
        count_new = add ? count_eff + 12'd1 : count_eff;
        sum_new   = add ? sum_eff + $signed({{15{obj[16]}}, obj}) : sum_eff;
        start_eff = start ? now : sess_start_reg;
        elapsed   = now - start_eff;
        done      = meas_eff && !remove && (elapsed >= {16'd0, cfg.window_ms});

        hand_next       = hand_reg;
        meas_next       = meas_reg;
        sess_start_next = sess_start_reg;
        last_start_next = last_start_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        if (accept) begin
            if (start) begin
                hand_next       = 1'b1;
                sess_start_next = now;
                last_start_next = now;
            end
            if (remove) begin
                hand_next = 1'b0;
                meas_next = 1'b0;
            end else if (meas_eff) begin
                meas_next  = !done;
                sum_next   = sum_new;
                count_next = count_new;
            end
        end

        q_push      = accept && (remove || (done && count_new != '0));
        q_job.kind  = remove ? hgta_pkg::EV_REMOVED : hgta_pkg::EV_FINISHED;
        q_job.sum   = sum_new;
        q_job.count = count_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_reg       <= 1'b0;
            meas_reg       <= 1'b0;
            sess_start_reg <= '0;
            last_start_reg <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
        end else begin
            hand_reg       <= hand_next;
            meas_reg       <= meas_next;
            sess_start_reg <= sess_start_next;
            last_start_reg <= last_start_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
        end
    end

    // a session only runs while the hand is held
    a_meas_needs_hand: assert property (@(posedge aclk) disable iff (!aresetn)
        meas_reg |-> hand_reg) else $error("session open without hand");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hgta_pkg::COUNT_CAP) else $error("sample count above cap");

endmodule
`default_nettype wire

@@ rtl/hgta_queue.sv @@
// Two-entry job queue between the front and back ends.
// Depends on hgta_pkg for the job type.
`default_nettype none
module hgta_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire hgta_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output hgta_pkg::job_t       head
);

    hgta_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop)) else $error("job queue overflow");

endmodule
`default_nettype wire

@@ rtl/hgta_back.sv @@
// Back end: pops jobs, runs a bit-serial divide for finished sessions, keeps the
// last result and drives the output register. Depends on hgta_pkg.
`default_nettype none
module hgta_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hgta_pkg::cfg_t  cfg,
    input  wire logic            q_not_empty,
    input  wire hgta_pkg::job_t  q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [4:0]                          step_reg, step_next;
    logic [31:0]                         quo_reg, quo_next;
    logic [hgta_pkg::CNT_W-1:0]          rem_reg, rem_next;
    logic [hgta_pkg::CNT_W-1:0]          div_reg, div_next;
    logic                                neg_reg, neg_next;
    logic                                kind_reg, kind_next;
    logic signed [hgta_pkg::TEMP_W-1:0]  avg_reg, avg_next;
    logic [hgta_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [hgta_pkg::TEMP_W-1:0]  last_reg, last_next;
    logic                                valid_reg, valid_next;
    logic [31:0]                         data_reg, data_next;
    logic                                user_reg, user_next;

    logic                                out_free, in_range;
    logic [hgta_pkg::CNT_W:0]            trial;
    logic [31:0]                         q_signed;

    assign out_free = !valid_reg || m_tready;
    assign in_range = (avg_reg >= cfg.temp_min) && (avg_reg <= cfg.temp_max);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        kind_next  = kind_reg;
        avg_next   = avg_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        q_pop      = 1'b0;
        trial      = {rem_reg, quo_reg[31]};
        q_signed   = neg_reg ? 32'd0 - quo_reg : quo_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (q_not_empty) begin
                    q_pop     = 1'b1;
                    kind_next = q_head.kind;
                    if (q_head.kind == hgta_pkg::EV_REMOVED) begin
                        avg_next   = last_reg;
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end else begin
                        neg_next   = q_head.sum[31];
                        quo_next   = q_head.sum[31] ? 32'd0 - q_head.sum : q_head.sum;
                        rem_next   = '0;
                        div_next   = q_head.count;
                        cnt_next   = q_head.count;
                        step_next  = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = hgta_pkg::CNT_W'(trial - {1'b0, div_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = trial[hgta_pkg::CNT_W-1:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (kind_reg == hgta_pkg::EV_FINISHED && step_reg == 5'd0) begin
                    // divide just ended: quotient to signed average
                    avg_next  = q_signed[hgta_pkg::TEMP_W-1:0];
                    last_next = q_signed[hgta_pkg::TEMP_W-1:0];
                    step_next = 5'd1;
                end else if (out_free) begin
                    valid_next = 1'b1;
                    data_next  = {2'b00, cnt_reg, in_range, avg_reg};
                    user_next  = kind_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        kind_reg <= kind_next;
        avg_reg  <= avg_next;
        cnt_reg  <= cnt_next;
        data_reg <= data_next;
        user_reg <= user_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            last_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> div_reg != '0) else $error("divide by zero count");

    a_removal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && kind_reg == hgta_pkg::EV_REMOVED) |-> cnt_reg == '0)
        else $error("removal carries a sample count");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == S_IDLE && q_not_empty) else $error("pop outside idle");

endmodule
`default_nettype wire

@@ rtl/hand_gated_temp_averager_top.sv @@
// Top level of the hand-gated temperature averager: config registers, front end,
// job queue and back end. Depends on hgta_pkg, hgta_front, hgta_queue, hgta_back.
//
// Usage:
//   Input transactions (s_tvalid/s_tready/s_tdata) carry one ambient reading,
//   one object reading and a millisecond timestamp. Each transaction gives zero
//   or one result on m_tvalid/m_tready/m_tdata/m_tuser: a finished session with
//   its average (m_tuser = 0) or a hand removal repeating the last average
//   (m_tuser = 1).
//   The front end takes one transaction per cycle while the two-entry job queue
//   has room. A removal result passes through the queue, the back end's idle and
//   output states and the output register to m_tvalid; a finished session also
//   runs the 32-step bit-serial divider first. The back end handles one job at a
//   time, so further jobs wait in the queue.
//   A stalled m_tready holds the output register, then the back end, then the
//   queue; s_tready drops only when the queue is full.
//   Reset (aresetn low, synchronous) loads register defaults and clears all
//   session state and the last average. Config writes (cfg_wr_en) take effect
//   at once and belong in idle periods.
`default_nettype none
module hand_gated_temp_averager_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [hgta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hgta_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [14:0] ambient_temp, [31:15] object_temp, [63:32] now_ms
    input  wire logic [63:0]                        s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [16:0] average_temp, [17] in_range, [29:18] sample_count, [31:30] zero
    output logic [31:0]                             m_tdata,
    // [0] event_kind
    output logic                                    m_tuser
);

    hgta_pkg::cfg_t cfg_reg, cfg_next;
    hgta_pkg::job_t push_job, head_job;
    logic           q_push, q_full, q_pop, q_not_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                hgta_pkg::CFG_HAND_THRESHOLD: cfg_next.hand_threshold = cfg_data[13:0];
                hgta_pkg::CFG_WINDOW_MS:      cfg_next.window_ms      = cfg_data[15:0];
                hgta_pkg::CFG_TEMP_MIN:       cfg_next.temp_min       = cfg_data;
                hgta_pkg::CFG_TEMP_MAX:       cfg_next.temp_max       = cfg_data;
                hgta_pkg::CFG_HOLDOFF_MS:     cfg_next.holdoff_ms     = cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hand_threshold <= hgta_pkg::RST_HAND_THRESHOLD;
            cfg_reg.window_ms      <= hgta_pkg::RST_WINDOW_MS;
            cfg_reg.temp_min       <= hgta_pkg::RST_TEMP_MIN;
            cfg_reg.temp_max       <= hgta_pkg::RST_TEMP_MAX;
            cfg_reg.holdoff_ms     <= hgta_pkg::RST_HOLDOFF_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hgta_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    hgta_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    hgta_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
`default_nettype wire
